[sv/stbs_pkg.sv]
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted table binary search core.
// ----------------------------------------------------------------------------
package stbs_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int ENTRY_W     = 32;
	localparam int BOUND_W     = 9;
	// Search bounds carry one extra bit: lo may pass the top, hi may drop to -1
	localparam int SPAN_W      = BOUND_W + 1;

	typedef logic signed [SPAN_W-1:0]  span_t;
	typedef logic signed [ENTRY_W-1:0] entry_t;
	typedef logic [ADDR_W-1:0]         addr_t;

	// Input word action codes
	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SEARCH = 1'b1;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CHECK,
		ST_FINISH
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic write_entry;   // store value at position
		logic start_search;  // capture target and bounds
		logic latch_probe;   // read table at mid, hold mid
		logic record_hit;    // mark found at mid
		logic move_up;       // lo <= mid + 1
		logic move_down;     // hi <= mid - 1
		logic load_result;   // fill output register
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic range_empty;   // lo > hi
		logic hit;           // probed entry equals target
		logic target_above;  // target greater than probed entry
	} status_t;

endpackage

[sv/stbs_ram.sv]
// ----------------------------------------------------------------------------
// stbs_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module stbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One access per cycle: write or read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end else if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/stbs_ctrl.sv]
// ----------------------------------------------------------------------------
// stbs_ctrl
// Sequencer for load and search words: probe, check, narrow, finish.
// ----------------------------------------------------------------------------
module stbs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  logic             action,
	output logic             result_valid,
	input  logic             result_stall,
	input  stbs_pkg::status_t sts,
	output stbs_pkg::cmd_t    cmd
);
	import stbs_pkg::*;

	state_t state_q, state_d;
	logic   result_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					if (action == ACT_LOAD) begin
						cmd.write_entry = 1'b1;
					end else begin
						cmd.start_search = 1'b1;
						state_d          = ST_PROBE;
					end
				end
			end
			ST_PROBE: begin
				if (sts.range_empty) begin
					state_d = ST_FINISH;
				end else begin
					cmd.latch_probe = 1'b1;
					state_d         = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.hit) begin
					cmd.record_hit = 1'b1;
					state_d        = ST_FINISH;
				end else if (sts.target_above) begin
					cmd.move_up = 1'b1;
					state_d     = ST_PROBE;
				end else begin
					cmd.move_down = 1'b1;
					state_d       = ST_PROBE;
				end
			end
			ST_FINISH: begin
				// wait for a free output register
				if (!result_valid_q || !result_stall) begin
					cmd.load_result = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.load_result) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;

	// A check always follows a probe that issued a read
	a_check_after_probe: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHECK |-> $past(state_q) == ST_PROBE)
		else $error("check state entered without a probe");

	// A finished search leaves a word in the output register
	a_finish_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_result |=> result_valid_q && state_q == ST_IDLE)
		else $error("finished search did not present a result");

	// Input words are taken only while no search is in flight
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.start_search || cmd.write_entry) |-> $past(state_d) == ST_IDLE
		|| state_q == ST_IDLE)
		else $error("input word taken while busy");

endmodule

[sv/stbs_dp.sv]
// ----------------------------------------------------------------------------
// stbs_dp
// Search datapath: bounds, midpoint, table RAM, compare and result register.
// ----------------------------------------------------------------------------
module stbs_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  stbs_pkg::cmd_t           cmd,
	output stbs_pkg::status_t        sts,
	input  logic [stbs_pkg::ADDR_W-1:0]  position,
	input  logic signed [stbs_pkg::ENTRY_W-1:0] value,
	input  logic [stbs_pkg::BOUND_W-1:0] lower_bound,
	input  logic signed [stbs_pkg::BOUND_W-1:0] upper_bound,
	output logic                     found,
	output logic [stbs_pkg::ADDR_W-1:0]  match_position
);
	import stbs_pkg::*;

	localparam span_t LAST_POS = span_t'(TABLE_DEPTH - 1);

	span_t  lo_q, hi_q, mid_q;
	span_t  mid_sum, mid, hi_ext;
	entry_t target_q, entry;
	logic   found_q;
	addr_t  match_q;
	logic   res_found_q;
	addr_t  res_pos_q;
	logic   ram_re;
	addr_t  ram_addr;
	logic [ENTRY_W-1:0] ram_rdata;

	// Midpoint: both bounds are non-negative whenever a probe is issued
	assign mid_sum = lo_q + hi_q;
	assign mid     = mid_sum >>> 1;
	assign hi_ext  = span_t'(upper_bound);

	// Table RAM: loads write at position, probes read at mid
	assign ram_re   = cmd.latch_probe;
	assign ram_addr = cmd.write_entry ? position : mid[ADDR_W-1:0];

	stbs_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (cmd.write_entry),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (value),
		.rdata (ram_rdata)
	);

	// Compare probed entry with target
	assign entry            = entry_t'(ram_rdata);
	assign sts.hit          = (entry == target_q);
	assign sts.target_above = (target_q > entry);
	assign sts.range_empty  = (lo_q > hi_q);

	// Search registers
	always_ff @(posedge clk) begin
		if (cmd.start_search) begin
			lo_q     <= span_t'({1'b0, lower_bound});
			hi_q     <= (hi_ext > LAST_POS) ? LAST_POS : hi_ext;
			target_q <= value;
			found_q  <= 1'b0;
			match_q  <= '0;
		end else begin
			if (cmd.latch_probe) begin
				mid_q <= mid;
			end
			if (cmd.move_up) begin
				lo_q <= mid_q + span_t'(1);
			end
			if (cmd.move_down) begin
				hi_q <= mid_q - span_t'(1);
			end
			if (cmd.record_hit) begin
				found_q <= 1'b1;
				match_q <= mid_q[ADDR_W-1:0];
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			res_found_q <= found_q;
			res_pos_q   <= match_q;
		end
	end

	assign found          = res_found_q;
	assign match_position = res_pos_q;

	// A probe is issued only into a non-empty range
	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch_probe |-> !sts.range_empty && mid >= lo_q && mid <= hi_q)
		else $error("probe outside search range");

endmodule

[sv/sorted_table_binary_search_core.sv]
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core
// Operation: a load word is written to the table RAM in the cycle it is taken.
// A search alternates probe and check states until a hit or an empty range,
// then a finish state registers the result. Each probe reads the table RAM
// (registered read) in the probe state, then compares and narrows in check.
// One word in flight; the next is taken once the result is registered.
// Reset (arst_n, async) clears controller and output valid; table is not cleared.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic                                 action,
	input  logic [stbs_pkg::ADDR_W-1:0]          position,
	input  logic signed [stbs_pkg::ENTRY_W-1:0]  value,
	input  logic [stbs_pkg::BOUND_W-1:0]         lower_bound,
	input  logic signed [stbs_pkg::BOUND_W-1:0]  upper_bound,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic                                 found,
	output logic [stbs_pkg::ADDR_W-1:0]          match_position
);
	import stbs_pkg::*;

	cmd_t    cmd;
	status_t sts;

	// Sequencer
	stbs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.action       (action),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	// Datapath with table RAM
	stbs_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.position       (position),
		.value          (value),
		.lower_bound    (lower_bound),
		.upper_bound    (upper_bound),
		.found          (found),
		.match_position (match_position)
	);

endmodule
